/* sv/wbca_pkg.sv */
// Shared types and constants for the word-aligned hybrid bitmap count accumulator.
// No dependencies.
package wbca_pkg;

	localparam int MAX_POSITIONS_DEF = 1024;
	localparam int COUNT_WIDTH_DEF   = 32;

	localparam int OPCODE_W   = 2;
	localparam int WORD_W     = 32;
	localparam int INDEX_W    = 10;
	localparam int COUNT_W    = 32;
	localparam int POS_W      = 11;
	localparam int GROUP_BITS = 31;
	localparam int RUN_W      = 30;
	localparam int SIZE_CMP_W = 17;

	localparam logic [POS_W-1:0] ACTIVE_SIZE_RST = POS_W'(1024);

	typedef enum logic [OPCODE_W-1:0] {
		OP_ADD     = 2'd0,
		OP_READ    = 2'd1,
		OP_RESTART = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD,
		ST_READ,
		ST_RESP
	} state_t;

endpackage

/* sv/wah_bitmap_count_accumulate.sv */
// An add word with set bits walks its positions in turn (31 per group, stopped at the
// active size); a zero word or skip only moves the position; a clear zeroes every
// counter. One counter read-modify-write per cycle on the single memory port pair.
// Throughput: one item at a time; the next transfer is taken once the result is registered.
// Reset: position 0, active size 1024; a clearing pass over all MAX_POSITIONS counters of the
// store runs first, with item_stall high (configuration writes still taken).
// Top level of the WAH bitmap count accumulator: decoder, sequencer and counter store.
// Depends on wbca_pkg.
module wah_bitmap_count_accumulate #(
	parameter int MAX_POSITIONS = wbca_pkg::MAX_POSITIONS_DEF,
	parameter int COUNT_WIDTH   = wbca_pkg::COUNT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wbca_pkg::POS_W-1:0]     cfg_data,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [wbca_pkg::OPCODE_W-1:0]  opcode,
	input  logic [wbca_pkg::WORD_W-1:0]    word,
	input  logic [wbca_pkg::INDEX_W-1:0]   index,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [wbca_pkg::COUNT_W-1:0]   count,
	output logic [wbca_pkg::POS_W-1:0]     position,
	output logic                           done_res
);
	import wbca_pkg::*;

	localparam int AW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
	localparam logic [SIZE_CMP_W-1:0] MaxW    = SIZE_CMP_W'(MAX_POSITIONS);
	localparam logic [AW-1:0]         ClrLast = AW'(MAX_POSITIONS - 1);

	// control state
	state_t            state_q, state_d;
	logic [AW-1:0]     clr_q;
	logic              clr_resp_q;
	logic              res_valid_q;
	logic              wr_en_s1;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  active_size_q;

	// datapath
	logic [POS_W-1:0]       end_q;
	logic [GROUP_BITS-1:0]  pattern_q;
	logic                   fill_q;
	logic                   rd_ok_q;
	logic [COUNT_WIDTH-1:0] res_count_q;
	logic [COUNT_WIDTH-1:0] rdata_q;
	logic [AW-1:0]          wr_addr_s1;
	logic                   wr_bit_s1;
	logic [COUNT_W-1:0]     count_q;
	logic [POS_W-1:0]       position_q;
	logic                   done_q;
	logic [COUNT_WIDTH-1:0] cnt_mem_q [MAX_POSITIONS];

	// memory port controls
	logic                   mem_re, mem_we;
	logic [AW-1:0]          mem_raddr, mem_waddr;
	logic [COUNT_WIDTH-1:0] mem_wdata;
	logic                   out_load;

	// decode of the word at the input
	logic                   accept;
	logic [POS_W-1:0]       limit;
	logic                   at_limit;
	logic [RUN_W-1:0]       groups;
	logic [6:0]             groups_sat;
	logic [11:0]            span;
	logic [POS_W+1:0]       sum;
	logic [POS_W-1:0]       end_calc;
	logic                   walk;
	logic                   in_range;

	assign cfg_ready = 1'b1;
	assign accept    = item_valid && !item_stall;

	assign limit    = (SIZE_CMP_W'(active_size_q) > MaxW) ? POS_W'(MAX_POSITIONS)
							: active_size_q;
	assign at_limit = pos_q >= limit;

	// zero fill of length 0 or 1 and literals both cover one group
	always_comb begin
		if (!word[31])
			groups = RUN_W'(1);
		else if (!word[30] && word[RUN_W-1:1] == '0)
			groups = RUN_W'(1);
		else
			groups = word[RUN_W-1:0];
	end

	// beyond 127 groups the position saturates anyway (limit < 2048)
	assign groups_sat = (word[31] && groups[RUN_W-1:7] != '0) ? 7'd127 : groups[6:0];
	assign span       = {groups_sat, 5'b0} - {5'b0, groups_sat};
	assign sum        = (POS_W+2)'(pos_q) + (POS_W+2)'(span);
	assign end_calc   = (sum >= (POS_W+2)'(limit)) ? limit : sum[POS_W-1:0];
	assign walk       = word[31] ? word[30] : (word[30:0] != '0);
	assign in_range   = SIZE_CMP_W'(index) < MaxW;

	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		mem_re     = 1'b0;
		mem_raddr  = AW'(pos_q);
		mem_we     = wr_en_s1;
		mem_waddr  = wr_addr_s1;
		mem_wdata  = rdata_q + COUNT_WIDTH'(wr_bit_s1);
		out_load   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == ClrLast)
					state_d = clr_resp_q ? ST_RESP : ST_IDLE;
			end
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					unique case (op_t'(opcode))
						OP_ADD: begin
							if (!at_limit && walk && end_calc != pos_q)
								state_d = ST_ADD;
							else
								state_d = ST_RESP;
						end
						OP_READ: begin
							mem_re    = 1'b1;
							mem_raddr = AW'(index);
							state_d   = ST_READ;
						end
						OP_RESTART: state_d = ST_RESP;
						OP_CLEAR:   state_d = ST_CLEAR;
					endcase
				end
			end
			ST_ADD: begin
				// read of the next position overlaps the write of the previous one
				mem_re = 1'b1;
				if (pos_q + POS_W'(1) == end_q)
					state_d = ST_RESP;
			end
			ST_READ: state_d = ST_RESP;
			ST_RESP: begin
				if (!res_valid_q || !res_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			clr_resp_q    <= 1'b0;
			res_valid_q   <= 1'b0;
			wr_en_s1      <= 1'b0;
			pos_q         <= '0;
			active_size_q <= ACTIVE_SIZE_RST;
		end else begin
			state_q  <= state_d;
			wr_en_s1 <= (state_q == ST_ADD);
			if (cfg_valid && cfg_ready)
				active_size_q <= cfg_data;
			if (state_q == ST_CLEAR)
				clr_q <= (clr_q == ClrLast) ? '0 : clr_q + AW'(1);
			if (accept)
				clr_resp_q <= (op_t'(opcode) == OP_CLEAR);
			if (out_load)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
			if (accept && op_t'(opcode) == OP_RESTART)
				pos_q <= '0;
			else if (accept && op_t'(opcode) == OP_ADD && !at_limit && !walk)
				pos_q <= end_calc;
			else if (state_q == ST_ADD)
				pos_q <= pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			end_q       <= end_calc;
			pattern_q   <= word[31] ? '1 : word[GROUP_BITS-1:0];
			fill_q      <= word[31];
			rd_ok_q     <= in_range;
			res_count_q <= '0;
		end
		if (state_q == ST_ADD) begin
			pattern_q  <= {pattern_q[GROUP_BITS-2:0], fill_q};
			wr_addr_s1 <= AW'(pos_q);
			wr_bit_s1  <= pattern_q[GROUP_BITS-1];
		end
		if (state_q == ST_READ)
			res_count_q <= rd_ok_q ? rdata_q : '0;
		if (out_load) begin
			count_q    <= COUNT_W'(res_count_q);
			position_q <= pos_q;
			done_q     <= at_limit;
		end
	end

	// counter store
	always_ff @(posedge clk) begin
		if (mem_we)
			cnt_mem_q[mem_waddr] <= mem_wdata;
		if (mem_re)
			rdata_q <= cnt_mem_q[mem_raddr];
	end

	assign res_valid = res_valid_q;
	assign count     = count_q;
	assign position  = position_q;
	assign done_res  = done_q;

endmodule

/* tb/sv/wah_bitmap_count_accumulate_test.sv */
// Self-checking testbench for wah_bitmap_count_accumulate: directed decode cases, active size
// extremes and random bitmap traffic with random idling, checked against a local predictor.
// Depends on wbca_pkg and the block's RTL.
module wah_bitmap_count_accumulate_test;
	timeunit 1ns;
	timeprecision 1ps;

	import wbca_pkg::*;

	localparam int NUM_POS        = MAX_POSITIONS_DEF;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS   = 1550;
	localparam int MAX_PRINTS     = 100;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [POS_W-1:0]   position;
		logic               done;
	} result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [POS_W-1:0]    cfg_data;
	logic                item_valid;
	logic                item_stall;
	logic [OPCODE_W-1:0] opcode;
	logic [WORD_W-1:0]   word;
	logic [INDEX_W-1:0]  index;
	logic                res_valid;
	logic                res_stall;
	logic [COUNT_W-1:0]  count;
	logic [POS_W-1:0]    position;
	logic                done_res;

	// predictor state
	logic [COUNT_W-1:0] model_counts [NUM_POS];
	int unsigned        model_pos;
	int unsigned        model_size;
	result_t            pending_results [$];
	result_t            oldest;

	int unsigned error_total;
	int unsigned items_sent;
	int unsigned results_checked;
	int unsigned size_writes;
	int unsigned quiet_cycles;
	bit          idle_on;

	wah_bitmap_count_accumulate u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.opcode(opcode),
		.word(word),
		.index(index),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.count(count),
		.position(position),
		.done_res(done_res)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned size_limit();
		return (model_size > NUM_POS) ? NUM_POS : model_size;
	endfunction

	function automatic void decode_word(input logic [WORD_W-1:0] w);
		int unsigned           limit;
		int unsigned           groups;
		logic [GROUP_BITS-1:0] bits;
		longint unsigned       next_pos;
		limit = size_limit();
		if (model_pos >= limit)
			return;
		if (w[31]) begin
			groups = w[RUN_W-1:0];
			bits = w[30] ? '1 : '0;
		end else begin
			groups = 1;
			bits = w[GROUP_BITS-1:0];
		end
		if (bits == '0) begin
			// zero runs only move the position; runs of zero or one still skip one group
			next_pos = longint'(model_pos) + longint'(groups > 1 ? groups : 1) * GROUP_BITS;
			model_pos = (next_pos >= limit) ? limit : 32'(next_pos);
			return;
		end
		for (int unsigned g = 0; g < groups; g++)
			for (int b = GROUP_BITS - 1; b >= 0; b--) begin
				if (model_pos < NUM_POS)
					model_counts[model_pos] = model_counts[model_pos] + bits[b];
				model_pos++;
				if (model_pos >= limit)
					return;
			end
	endfunction

	function automatic result_t predict_result(input op_t op, input logic [WORD_W-1:0] w,
			input logic [INDEX_W-1:0] idx);
		result_t r;
		r.count = '0;
		case (op)
			OP_ADD: decode_word(w);
			OP_READ: r.count = model_counts[idx];
			OP_RESTART: model_pos = 0;
			OP_CLEAR: foreach (model_counts[i]) model_counts[i] = '0;
		endcase
		r.position = model_pos[POS_W-1:0];
		r.done = (model_pos >= size_limit());
		return r;
	endfunction

	task automatic flag_mismatch(input string what);
		error_total++;
		if (error_total <= MAX_PRINTS)
			$display("%0t mismatch: %s", $time, what);
	endtask

	// result checker: oldest expectation against each result transfer
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result count=%h position=%0d done=%b",
					count, position, done_res));
			end else begin
				oldest = pending_results.pop_front();
				results_checked++;
				if (count !== oldest.count)
					flag_mismatch($sformatf("count %h, want %h", count, oldest.count));
				if (position !== oldest.position)
					flag_mismatch($sformatf("position %0d, want %0d", position, oldest.position));
				if (done_res !== oldest.done)
					flag_mismatch($sformatf("done_res %b, want %b", done_res, oldest.done));
			end
		end
	end

	// result side back-pressure: mostly short stalls, a few long ones
	initial begin
		int hold;
		hold = 0;
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				res_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 99) < 30) begin
				hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles, %0d results outstanding",
				quiet_cycles, pending_results.size());
			$display("[wah_bitmap_count_accumulate] ERROR");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// valid stays high after a transfer; it is dropped by a gap or at the end of a phase
	task automatic send_item(input op_t op, input logic [WORD_W-1:0] w,
			input logic [INDEX_W-1:0] idx);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		opcode <= op;
		word <= w;
		index <= idx;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		pending_results.push_back(predict_result(op, w, idx));
		items_sent++;
	endtask

	task automatic finish_phase();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_size(input logic [POS_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		model_size = value;
		size_writes++;
	endtask

	function automatic logic [WORD_W-1:0] random_add_word();
		logic [RUN_W-1:0] run;
		run = ($urandom_range(0, 7) == 0) ? RUN_W'($urandom()) : RUN_W'($urandom_range(0, 3));
		case ($urandom_range(0, 9))
			0, 1, 2: return {1'b0, 31'($urandom())};
			3: return {1'b0, 31'($urandom() & $urandom() & $urandom())};
			4: return '0;
			5, 6: return {2'b11, run};
			7, 8: return {2'b10, run};
			default: return $urandom();
		endcase
	endfunction

	// mostly positions already decoded, so reads tend to see nonzero counters
	function automatic logic [INDEX_W-1:0] pick_index();
		if (model_pos == 0 || $urandom_range(0, 3) == 0)
			return INDEX_W'($urandom());
		return INDEX_W'($urandom_range(0, model_pos - 1));
	endfunction

	function automatic logic [POS_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			case ($urandom_range(0, 4))
				0: return POS_W'(0);
				1: return POS_W'(1);
				2: return POS_W'(31);
				3: return POS_W'(2047);
				default: return POS_W'(NUM_POS);
			endcase
		end
		if (r < 30)
			return POS_W'($urandom_range(1, 100));
		if (r < 35)
			return POS_W'($urandom_range(NUM_POS + 1, 2047));
		return POS_W'($urandom_range(1, NUM_POS));
	endfunction

	// restart, a run of add words, then reads; some runs continue without a restart; clears and single items interleave
	task automatic run_traffic(input int unsigned amount);
		int unsigned stop_at;
		int          r;
		stop_at = items_sent + amount;
		while (items_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				send_item(OP_CLEAR, $urandom(), INDEX_W'($urandom()));
			end else if (r < 12) begin
				send_item(op_t'($urandom_range(0, 2)), $urandom(), INDEX_W'($urandom()));
			end else begin
				if (r >= 25)
					send_item(OP_RESTART, $urandom(), INDEX_W'($urandom()));
				repeat ($urandom_range(1, 6))
					send_item(OP_ADD, random_add_word(), INDEX_W'($urandom()));
				repeat ($urandom_range(1, 3))
					send_item(OP_READ, $urandom(), pick_index());
			end
		end
	endtask

	task automatic test_decode_cases();
		idle_on = 1'b1;
		send_item(OP_READ, '0, '0);
		send_item(OP_ADD, 32'h7FFF_FFFF, '0);
		send_item(OP_ADD, 32'h4000_0000, '0);   // first bit of the group only
		send_item(OP_ADD, 32'h0000_0001, '0);   // last bit of the group only
		send_item(OP_ADD, 32'h0000_0000, '0);   // zero literal skips a group
		send_item(OP_ADD, 32'h8000_0000, '0);   // zero fill, length zero
		send_item(OP_ADD, 32'h8000_0001, '0);   // zero fill, length one
		send_item(OP_ADD, 32'h8000_0003, '0);
		send_item(OP_ADD, 32'hC000_0000, '0);   // empty one fill
		send_item(OP_ADD, 32'hC000_0002, '0);
		send_item(OP_READ, '0, 10'd0);
		send_item(OP_READ, '0, 10'd30);
		send_item(OP_READ, '0, 10'd31);
		send_item(OP_READ, '0, 10'd92);
		send_item(OP_READ, '0, 10'd340);
		send_item(OP_ADD, 32'hBFFF_FFFF, '0);   // longest zero fill saturates at the size
		send_item(OP_ADD, 32'h7FFF_FFFF, '0);   // ignored once done
		send_item(OP_RESTART, '0, '0);
		send_item(OP_ADD, 32'hFFFF_FFFF, '0);   // longest one fill walks every position
		send_item(OP_READ, '0, 10'd1023);
		send_item(OP_READ, '0, 10'd0);
		send_item(OP_CLEAR, '0, '0);
		send_item(OP_READ, '0, 10'd0);
		send_item(OP_RESTART, 32'hFFFF_FFFF, 10'h3FF);
		finish_phase();
	endtask

	task automatic test_size_limits();
		logic [POS_W-1:0] sizes [6] = '{11'd0, 11'd1, 11'd31, 11'd32, 11'd2047, 11'd1024};
		foreach (sizes[i]) begin
			idle_on = (i % 2 == 0);
			write_size(sizes[i]);
			run_traffic(25);
			finish_phase();
		end
		// size lowered below the current position: position kept, done set
		send_item(OP_RESTART, '0, '0);
		send_item(OP_ADD, 32'hC000_000A, '0);
		finish_phase();
		write_size(11'd100);
		send_item(OP_READ, '0, 10'd309);
		send_item(OP_ADD, 32'h7FFF_FFFF, '0);
		send_item(OP_RESTART, '0, '0);
		send_item(OP_ADD, 32'h5555_5555, '0);
		finish_phase();
	endtask

	task automatic test_random_traffic();
		int unsigned stop_at;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			idle_on = ($urandom_range(0, 3) != 0);
			write_size(pick_size());
			run_traffic(50);
			finish_phase();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		item_valid = 1'b0;
		opcode = OP_ADD;
		word = '0;
		index = '0;
		idle_on = 1'b0;
		error_total = 0;
		items_sent = 0;
		results_checked = 0;
		size_writes = 0;
		quiet_cycles = 0;
		foreach (model_counts[i]) model_counts[i] = '0;
		model_pos = 0;
		model_size = NUM_POS;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_decode_cases();
		test_size_limits();
		test_random_traffic();

		// any stray result in this window is flagged by the checker
		idle_on = 1'b0;
		repeat (64) @(posedge clk);

		$display("Sent %0d items over %0d active size settings, checked %0d results.",
			items_sent, size_writes, results_checked);
		$display("Literals, zero and one fills, size saturation, reads, restarts, clears: %0d errors.",
			error_total);
		if (error_total == 0)
			$display("[wah_bitmap_count_accumulate] OK");
		else
			$display("[wah_bitmap_count_accumulate] ERROR");
		$finish;
	end

endmodule
